@@ rtl/core/ifcs_pkg.sv @@
// Shared types, codes and constants of the IPv4 frame classifier with statistics.
package ifcs_pkg;

    localparam int COUNTER_WIDTH_DEF   = 48;
    localparam int MAX_FRAME_BYTES_DEF = 65536;
    localparam int HIST_BUCKETS_DEF    = 11;

    localparam int PROTO_SLOTS    = 256;
    localparam int PROTO_AW       = 8;
    localparam int SUMMARY_COUNT  = 7;
    localparam int LEN_W          = 17;
    localparam int SEL_W          = 9;
    localparam int VALUE_W        = 48;
    localparam int BUCKET_W       = 4;
    localparam int OUT_FIFO_DEPTH = 8;

    localparam logic [15:0] ETH_TYPE_VLAN = 16'h8100;
    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;

    localparam logic [7:0] IP_PROTO_ICMP = 8'h01;
    localparam logic [7:0] IP_PROTO_TCP  = 8'h06;
    localparam logic [7:0] IP_PROTO_UDP  = 8'h11;

    localparam logic [BUCKET_W-1:0] BUCKET_NONE = 4'hF;

    typedef enum logic [0:0] {
        OP_FRAME_BYTE,
        OP_COUNTER_READ
    } opcode_t;

    typedef enum logic [0:0] {
        RK_CLASSIFY,
        RK_COUNTER
    } result_kind_t;

    typedef enum logic [2:0] {
        ST_COUNTED,
        ST_RUNT,
        ST_NOT_IPV4,
        ST_BAD_IP_HDR,
        ST_FILTERED
    } frame_status_t;

    typedef enum logic [2:0] {
        SUM_PACKETS,
        SUM_BYTES,
        SUM_IP,
        SUM_TCP,
        SUM_UDP,
        SUM_ICMP,
        SUM_OTHER
    } summary_idx_t;

    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_SUMMARY,
        SRC_HIST,
        SRC_PROTO
    } read_src_t;

    // Snapshot handed from the parser: a finished frame or a counter read request.
    typedef struct packed {
        logic                 valid;
        opcode_t              op;
        logic [SEL_W-1:0]     sel;
        logic [LEN_W-1:0]     len;
        logic                 vlan;
        logic [15:0]          ether_type;
        logic [5:0]           ihl;
        logic [7:0]           ttl;
        logic [7:0]           proto;
        logic [15:0]          sp;
        logic [15:0]          dp;
        logic [5:0]           flags;
    } frame_event_t;

    typedef struct packed {
        result_kind_t         kind;
        frame_status_t        status;
        logic [7:0]           proto;
        logic [15:0]          sp;
        logic [15:0]          dp;
        logic [7:0]           ttl;
        logic [5:0]           flags;
        logic [LEN_W-1:0]     len;
        logic [BUCKET_W-1:0]  bucket;
        logic [VALUE_W-1:0]   value;
    } result_t;

endpackage

@@ rtl/core/ifcs_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module ifcs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read-before-write: a read of the address being written returns the old word.
    always_ff @(posedge aclk) begin
        rdata_reg <= mem_reg[raddr];
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/ifcs_parser.sv @@
// Byte-wise Ethernet, VLAN, IPv4 and L4 header field extraction.
module ifcs_parser #(
    parameter int MAX_FRAME_BYTES = ifcs_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_accept,
    input  ifcs_pkg::opcode_t     in_opcode,
    input  logic [7:0]            in_byte,
    input  logic                  in_last,
    input  logic [8:0]            in_sel,
    output ifcs_pkg::frame_event_t ev_out
);
    import ifcs_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME_BYTES);

    logic [LEN_W-1:0] pos_reg, pos_next;
    logic [15:0]      et_reg, et_next;
    logic             vlan_reg, vlan_next;
    logic [5:0]       ihl_reg, ihl_next;
    logic [7:0]       ttl_reg, ttl_next;
    logic [7:0]       proto_reg, proto_next;
    logic [15:0]      sp_reg, sp_next;
    logic [15:0]      dp_reg, dp_next;
    logic [5:0]       flags_reg, flags_next;
    frame_event_t     ev_reg, ev_next;

    logic             in_range;
    logic [LEN_W-1:0] ip_start;
    logic [LEN_W-1:0] q_pos;
    logic [LEN_W-1:0] r_pos;
    logic [LEN_W-1:0] ihl_ext;

    always_comb begin
        in_range = pos_reg < MAX_LEN;
        ip_start = vlan_reg ? LEN_W'(18) : LEN_W'(14);
        ihl_ext  = LEN_W'(ihl_reg);
        q_pos    = pos_reg - ip_start;
        r_pos    = q_pos - ihl_ext;

        pos_next   = pos_reg;
        et_next    = et_reg;
        vlan_next  = vlan_reg;
        ihl_next   = ihl_reg;
        ttl_next   = ttl_reg;
        proto_next = proto_reg;
        sp_next    = sp_reg;
        dp_next    = dp_reg;
        flags_next = flags_reg;

        if (in_accept && in_opcode == OP_FRAME_BYTE && in_range) begin
            pos_next = pos_reg + LEN_W'(1);
            if (pos_reg == LEN_W'(12)) begin
                et_next[15:8] = in_byte;
            end
            if (pos_reg == LEN_W'(13)) begin
                et_next[7:0] = in_byte;
                if ({et_reg[15:8], in_byte} == ETH_TYPE_VLAN) begin
                    vlan_next = 1'b1;
                end
            end
            // The inner EtherType of a tagged frame replaces the outer one.
            if (vlan_reg && pos_reg == LEN_W'(16)) begin
                et_next[15:8] = in_byte;
            end
            if (vlan_reg && pos_reg == LEN_W'(17)) begin
                et_next[7:0] = in_byte;
            end
            if (pos_reg >= ip_start) begin
                if (q_pos == LEN_W'(0)) begin
                    ihl_next = {in_byte[3:0], 2'b00};
                end
                if (q_pos == LEN_W'(8)) begin
                    ttl_next = in_byte;
                end
                if (q_pos == LEN_W'(9)) begin
                    proto_next = in_byte;
                end
                if (ihl_reg >= 6'd20 && q_pos >= ihl_ext) begin
                    if (r_pos == LEN_W'(0)) sp_next[15:8] = in_byte;
                    if (r_pos == LEN_W'(1)) sp_next[7:0] = in_byte;
                    if (r_pos == LEN_W'(2)) dp_next[15:8] = in_byte;
                    if (r_pos == LEN_W'(3)) dp_next[7:0] = in_byte;
                    if (r_pos == LEN_W'(13)) flags_next = in_byte[5:0];
                end
            end
        end

        // The snapshot includes the effect of the final byte itself.
        ev_next.valid      = in_accept && (in_opcode == OP_COUNTER_READ || in_last);
        ev_next.op         = in_opcode;
        ev_next.sel        = in_sel;
        ev_next.len        = pos_next;
        ev_next.vlan       = vlan_next;
        ev_next.ether_type = et_next;
        ev_next.ihl        = ihl_next;
        ev_next.ttl        = ttl_next;
        ev_next.proto      = proto_next;
        ev_next.sp         = sp_next;
        ev_next.dp         = dp_next;
        ev_next.flags      = flags_next;

        if (in_accept && in_opcode == OP_FRAME_BYTE && in_last) begin
            pos_next   = '0;
            et_next    = '0;
            vlan_next  = 1'b0;
            ihl_next   = '0;
            ttl_next   = '0;
            proto_next = '0;
            sp_next    = '0;
            dp_next    = '0;
            flags_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            et_reg    <= '0;
            vlan_reg  <= 1'b0;
            ihl_reg   <= '0;
            ttl_reg   <= '0;
            proto_reg <= '0;
            sp_reg    <= '0;
            dp_reg    <= '0;
            flags_reg <= '0;
            ev_reg    <= '0;
        end else begin
            pos_reg   <= pos_next;
            et_reg    <= et_next;
            vlan_reg  <= vlan_next;
            ihl_reg   <= ihl_next;
            ttl_reg   <= ttl_next;
            proto_reg <= proto_next;
            sp_reg    <= sp_next;
            dp_reg    <= dp_next;
            flags_reg <= flags_next;
            ev_reg    <= ev_next;
        end
    end

    assign ev_out = ev_reg;

endmodule

@@ rtl/core/ifcs_stats.sv @@
// Frame classification and statistics counters kept in RAM with read-modify-write.
module ifcs_stats #(
    parameter int COUNTER_WIDTH = ifcs_pkg::COUNTER_WIDTH_DEF,
    parameter int HIST_BUCKETS  = ifcs_pkg::HIST_BUCKETS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [15:0]            port_match,
    input  ifcs_pkg::frame_event_t ev_in,
    output logic                   busy,
    output logic                   res_valid,
    output ifcs_pkg::result_t      res
);
    import ifcs_pkg::*;

    localparam int CW      = COUNTER_WIDTH;
    localparam int HIST_AW = (HIST_BUCKETS > 1) ? $clog2(HIST_BUCKETS) : 1;

    localparam logic [SEL_W-1:0] HIST_BASE  = SEL_W'(SUMMARY_COUNT);
    localparam logic [SEL_W-1:0] PROTO_BASE = SEL_W'(SUMMARY_COUNT + HIST_BUCKETS);
    localparam logic [SEL_W-1:0] PROTO_END  = SEL_W'(SUMMARY_COUNT + HIST_BUCKETS + PROTO_SLOTS);

    typedef struct packed {
        logic                 valid;
        result_kind_t         kind;
        frame_status_t        status;
        logic [7:0]           proto;
        logic [15:0]          sp;
        logic [15:0]          dp;
        logic [7:0]           ttl;
        logic [5:0]           flags;
        logic [LEN_W-1:0]     len;
        logic [BUCKET_W-1:0]  bucket;
        logic                 counted;
        logic                 hist_upd;
        read_src_t            src;
        summary_idx_t         sum_idx;
        logic [HIST_AW-1:0]   hist_addr;
        logic [PROTO_AW-1:0]  proto_addr;
        logic                 hist_vld;
        logic                 proto_vld;
    } upd_stage_t;

    upd_stage_t c_reg, c_next;

    logic [CW-1:0] sum_reg  [SUMMARY_COUNT];
    logic [CW-1:0] sum_next [SUMMARY_COUNT];
    logic [HIST_BUCKETS-1:0] hist_valid_reg, hist_valid_next;
    logic [PROTO_SLOTS-1:0]  proto_valid_reg, proto_valid_next;

    logic          fwd_hist_hit_reg, fwd_proto_hit_reg;
    logic [CW-1:0] fwd_hist_data_reg, fwd_proto_data_reg;

    // Classification of the incoming snapshot.
    logic                runt, not_ip, bad_hdr, tcp_full, udp_full, filtered;
    logic [LEN_W-1:0]    ip_start, avail, ihl_ext, l4_avail;
    logic [15:0]         sp_ok, dp_ok;
    logic [5:0]          fl_ok;
    logic [BUCKET_W-1:0] bucket;
    logic [SEL_W-1:0]    hist_off, proto_off;
    logic [HIST_AW-1:0]  hist_raddr;
    logic [PROTO_AW-1:0] proto_raddr;

    // Update stage.
    logic                hist_we, proto_we;
    logic [CW-1:0]       hist_rdata, proto_rdata;
    logic [CW-1:0]       hist_cur, proto_cur;
    logic [CW-1:0]       hist_wdata, proto_wdata;
    logic [CW-1:0]       read_raw;
    logic [CW+VALUE_W-1:0] read_ext;
    summary_idx_t        class_idx;

    always_comb begin
        runt     = ev_in.len < LEN_W'(14);
        not_ip   = (ev_in.vlan && ev_in.len <= LEN_W'(18)) ||
                   (ev_in.ether_type != ETH_TYPE_IPV4);
        ip_start = ev_in.vlan ? LEN_W'(18) : LEN_W'(14);
        avail    = ev_in.len - ip_start;
        ihl_ext  = LEN_W'(ev_in.ihl);
        bad_hdr  = avail < LEN_W'(20) || ev_in.ihl < 6'd20 || ihl_ext > avail;
        l4_avail = avail - ihl_ext;
        tcp_full = ev_in.proto == IP_PROTO_TCP && l4_avail >= LEN_W'(20);
        udp_full = ev_in.proto == IP_PROTO_UDP && l4_avail >= LEN_W'(8);
        sp_ok    = (tcp_full || udp_full) ? ev_in.sp : '0;
        dp_ok    = (tcp_full || udp_full) ? ev_in.dp : '0;
        fl_ok    = tcp_full ? ev_in.flags : '0;
        filtered = port_match != 16'd0 && sp_ok != port_match && dp_ok != port_match;

        // Walk down so that the smallest fitting limit wins.
        bucket = BUCKET_NONE;
        for (int i = HIST_BUCKETS - 1; i >= 0; i--) begin
            if (22'(ev_in.len) <= (22'd64 << i)) begin
                bucket = BUCKET_W'(i);
            end
        end

        hist_off    = ev_in.sel - HIST_BASE;
        proto_off   = ev_in.sel - PROTO_BASE;
        hist_raddr  = bucket[HIST_AW-1:0];
        proto_raddr = ev_in.proto;

        c_next       = '0;
        c_next.valid = ev_in.valid;

        if (ev_in.op == OP_COUNTER_READ) begin
            c_next.kind = RK_COUNTER;
            priority if (ev_in.sel < HIST_BASE) begin
                c_next.src     = SRC_SUMMARY;
                c_next.sum_idx = summary_idx_t'(ev_in.sel[2:0]);
            end else if (ev_in.sel < PROTO_BASE) begin
                c_next.src = SRC_HIST;
                hist_raddr = hist_off[HIST_AW-1:0];
            end else if (ev_in.sel < PROTO_END) begin
                c_next.src  = SRC_PROTO;
                proto_raddr = proto_off[PROTO_AW-1:0];
            end else begin
                c_next.src = SRC_NONE;
            end
        end else begin
            c_next.kind   = RK_CLASSIFY;
            c_next.len    = ev_in.len;
            c_next.bucket = bucket;
            priority if (runt) begin
                c_next.status = ST_RUNT;
            end else if (not_ip) begin
                c_next.status = ST_NOT_IPV4;
            end else if (bad_hdr) begin
                c_next.status = ST_BAD_IP_HDR;
            end else begin
                c_next.ttl   = ev_in.ttl;
                c_next.proto = ev_in.proto;
                c_next.sp    = sp_ok;
                c_next.dp    = dp_ok;
                c_next.flags = fl_ok;
                if (filtered) begin
                    c_next.status = ST_FILTERED;
                end else begin
                    c_next.status  = ST_COUNTED;
                    c_next.counted = 1'b1;
                end
            end
            c_next.hist_upd = c_next.counted &&
                              ({1'b0, bucket} < (BUCKET_W + 1)'(HIST_BUCKETS));
        end

        c_next.hist_addr  = hist_raddr;
        c_next.proto_addr = proto_raddr;
        c_next.hist_vld   = ((HIST_AW + 1)'(hist_raddr) < (HIST_AW + 1)'(HIST_BUCKETS)) &&
                            hist_valid_reg[hist_raddr];
        c_next.proto_vld  = proto_valid_reg[proto_raddr];
    end

    ifcs_ram #(
        .WIDTH (CW),
        .DEPTH (HIST_BUCKETS)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (hist_we),
        .waddr (c_reg.hist_addr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    ifcs_ram #(
        .WIDTH (CW),
        .DEPTH (PROTO_SLOTS)
    ) u_proto_ram (
        .aclk  (aclk),
        .we    (proto_we),
        .waddr (c_reg.proto_addr),
        .wdata (proto_wdata),
        .raddr (proto_raddr),
        .rdata (proto_rdata)
    );

    always_comb begin
        // A write in the previous cycle to the entry just read is not yet in the RAM data.
        hist_cur  = fwd_hist_hit_reg  ? fwd_hist_data_reg  :
                    (c_reg.hist_vld  ? hist_rdata  : '0);
        proto_cur = fwd_proto_hit_reg ? fwd_proto_data_reg :
                    (c_reg.proto_vld ? proto_rdata : '0);

        hist_we     = c_reg.valid && c_reg.hist_upd;
        proto_we    = c_reg.valid && c_reg.counted;
        hist_wdata  = hist_cur + CW'(1);
        proto_wdata = proto_cur + CW'(1);

        priority if (c_reg.proto == IP_PROTO_TCP) begin
            class_idx = SUM_TCP;
        end else if (c_reg.proto == IP_PROTO_UDP) begin
            class_idx = SUM_UDP;
        end else if (c_reg.proto == IP_PROTO_ICMP) begin
            class_idx = SUM_ICMP;
        end else begin
            class_idx = SUM_OTHER;
        end

        sum_next         = sum_reg;
        hist_valid_next  = hist_valid_reg;
        proto_valid_next = proto_valid_reg;
        if (proto_we) begin
            sum_next[SUM_PACKETS] = sum_reg[SUM_PACKETS] + CW'(1);
            sum_next[SUM_BYTES]   = sum_reg[SUM_BYTES] + CW'(c_reg.len);
            sum_next[SUM_IP]      = sum_reg[SUM_IP] + CW'(1);
            sum_next[class_idx]   = sum_reg[class_idx] + CW'(1);
            proto_valid_next[c_reg.proto_addr] = 1'b1;
        end
        if (hist_we) begin
            hist_valid_next[c_reg.hist_addr] = 1'b1;
        end

        unique case (c_reg.src)
            SRC_SUMMARY: read_raw = sum_reg[c_reg.sum_idx];
            SRC_HIST:    read_raw = hist_cur;
            SRC_PROTO:   read_raw = proto_cur;
            SRC_NONE:    read_raw = '0;
        endcase
        read_ext = {VALUE_W'(0), read_raw};

        res.kind   = c_reg.kind;
        res.status = c_reg.status;
        res.proto  = c_reg.proto;
        res.sp     = c_reg.sp;
        res.dp     = c_reg.dp;
        res.ttl    = c_reg.ttl;
        res.flags  = c_reg.flags;
        res.len    = c_reg.len;
        res.bucket = c_reg.bucket;
        res.value  = (c_reg.kind == RK_COUNTER) ? read_ext[VALUE_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_reg             <= '0;
            hist_valid_reg    <= '0;
            proto_valid_reg   <= '0;
            fwd_hist_hit_reg  <= 1'b0;
            fwd_proto_hit_reg <= 1'b0;
            for (int i = 0; i < SUMMARY_COUNT; i++) begin
                sum_reg[i] <= '0;
            end
        end else begin
            c_reg             <= c_next;
            hist_valid_reg    <= hist_valid_next;
            proto_valid_reg   <= proto_valid_next;
            fwd_hist_hit_reg  <= hist_we && (c_reg.hist_addr == hist_raddr);
            fwd_proto_hit_reg <= proto_we && (c_reg.proto_addr == proto_raddr);
            sum_reg           <= sum_next;
        end
        fwd_hist_data_reg  <= hist_wdata;
        fwd_proto_data_reg <= proto_wdata;
    end

    assign busy      = c_reg.valid;
    assign res_valid = c_reg.valid;

endmodule

@@ rtl/core/ifcs_out_fifo.sv @@
// Result queue between the update stage and the output channel.
module ifcs_out_fifo #(
    parameter int DEPTH = ifcs_pkg::OUT_FIFO_DEPTH,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  ifcs_pkg::result_t push_data,
    input  logic              pop_ready,
    output logic              out_valid,
    output ifcs_pkg::result_t out_data,
    output logic [CNT_W-1:0]  count
);
    import ifcs_pkg::*;

    result_t          mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    always_comb begin
        pop         = out_valid && pop_ready;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

@@ rtl/core/ipv4_frame_classifier_stats_core.sv @@
// Top level of the Ethernet/IPv4 frame classifier with traffic statistics.
//
//  channel   direction  handshake          payload
//  s_        in         tvalid/tready      tdata frame byte, counter select; tlast; tuser opcode
//  m_        out        tvalid/tready      tdata classification or counter value; tuser kind
//  cfg_      in         cfg_wr_en          cfg_wr_data port match filter
//
// One request is taken per cycle while s_tready is high. A final frame byte or a counter read
// passes the parser snapshot, then RAM read and classification, then counter update, and is
// written into the output queue with that update; m_tvalid is high while the queue holds a result.
// The per-protocol and histogram counters live in RAMs; their read-modify-write is
// forwarded when a read of the same entry directly follows the write.
// Reset clears the valid bits of both RAMs at once, so there is no clearing pass.
// s_tready drops only when the eight-entry output queue, counting requests in flight,
// is full; a stalled m_ side therefore does not stop input until the queue fills.
module ipv4_frame_classifier_stats_core #(
    parameter int COUNTER_WIDTH   = ifcs_pkg::COUNTER_WIDTH_DEF,
    parameter int MAX_FRAME_BYTES = ifcs_pkg::MAX_FRAME_BYTES_DEF,
    parameter int HIST_BUCKETS    = ifcs_pkg::HIST_BUCKETS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // frame_byte [7:0], counter_select [16:8], zero [23:17]
    input  logic         s_tlast,
    input  logic [0:0]   s_tuser,   // opcode [0]

    output logic         m_tvalid,
    input  logic         m_tready,
    // frame_status [2:0], ip_protocol [10:3], source_port [26:11], dest_port [42:27],
    // time_to_live [50:43], tcp_flag_bits [56:51], frame_length [73:57],
    // size_bucket [77:74], counter_value [125:78], zero [127:126]
    output logic [127:0] m_tdata,
    output logic [0:0]   m_tuser,   // result_kind [0]

    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data
);
    import ifcs_pkg::*;

    localparam int CNT_W = $clog2(OUT_FIFO_DEPTH + 1);
    localparam int OCC_W = $clog2(OUT_FIFO_DEPTH + 3) + 1;

    logic [15:0]      port_match_reg;
    logic             in_accept;
    frame_event_t     ev;
    logic             stats_busy;
    logic             res_valid;
    result_t          res;
    result_t          out_res;
    logic [CNT_W-1:0] fifo_count;
    logic [OCC_W-1:0] occupancy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            port_match_reg <= '0;
        end else if (cfg_wr_en) begin
            port_match_reg <= cfg_wr_data;
        end
    end

    // Every request in flight holds a queue slot in reserve.
    assign occupancy = OCC_W'(fifo_count) + OCC_W'(ev.valid) + OCC_W'(stats_busy);
    assign s_tready  = occupancy < OCC_W'(OUT_FIFO_DEPTH);
    assign in_accept = s_tvalid && s_tready;

    ifcs_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_opcode (opcode_t'(s_tuser[0])),
        .in_byte   (s_tdata[7:0]),
        .in_last   (s_tlast),
        .in_sel    (s_tdata[16:8]),
        .ev_out    (ev)
    );

    ifcs_stats #(
        .COUNTER_WIDTH (COUNTER_WIDTH),
        .HIST_BUCKETS  (HIST_BUCKETS)
    ) u_stats (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .port_match (port_match_reg),
        .ev_in      (ev),
        .busy       (stats_busy),
        .res_valid  (res_valid),
        .res        (res)
    );

    ifcs_out_fifo #(
        .DEPTH (OUT_FIFO_DEPTH)
    ) u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .pop_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .count     (fifo_count)
    );

    assign m_tdata = {2'b00, out_res.value, out_res.bucket, out_res.len, out_res.flags,
                      out_res.ttl, out_res.dp, out_res.sp, out_res.proto, out_res.status};
    assign m_tuser = out_res.kind;

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the IPv4 frame classifier core with traffic statistics.
`timescale 1ns / 100ps

module tb_top;
    import ifcs_pkg::*;

    localparam int CNT_W          = COUNTER_WIDTH_DEF;
    localparam int FRAME_LIMIT    = MAX_FRAME_BYTES_DEF;
    localparam int NUM_BUCKETS    = HIST_BUCKETS_DEF;
    localparam int PROTO_SEL_BASE = SUMMARY_COUNT + NUM_BUCKETS;
    localparam int SEL_MAX        = (1 << SEL_W) - 1;
    localparam int SETTLE_CYCLES  = 8;
    localparam int END_CYCLES     = 16;
    localparam int STALL_LIMIT    = 5000;
    localparam int SEG_REQUESTS   = 30;
    localparam int SEG_FRAMES     = 1;

    typedef struct {
        opcode_t    op;
        logic [7:0] data;
        logic       last;
        logic [8:0] sel;
    } request_t;

    logic         aclk        = 1'b0;
    logic         aresetn     = 1'b0;
    logic         s_tvalid    = 1'b0;
    logic         s_tready;
    logic [23:0]  s_tdata     = '0;
    logic         s_tlast     = 1'b0;
    logic [0:0]   s_tuser     = '0;
    logic         m_tvalid;
    logic         m_tready    = 1'b0;
    logic [127:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_wr_en   = 1'b0;
    logic [15:0]  cfg_wr_data = '0;

    request_t pending_requests[$];
    request_t in_flight;
    result_t  expected_results[$];

    int send_idle_pct = 27;
    int recv_idle_pct = 69;
    int error_count   = 0;
    int stall_cycles  = 0;
    int queued_items  = 0;
    int queued_frames = 0;

    // Shadow of the block: filter register, parser state and statistics counters.
    logic [15:0]      port_filter = '0;
    int               frm_pos     = 0;
    logic [15:0]      frm_etype   = '0;
    logic             frm_vlan    = 1'b0;
    int               frm_ihl     = 0;
    logic [7:0]       frm_ttl     = '0;
    logic [7:0]       frm_proto   = '0;
    logic [15:0]      frm_sp      = '0;
    logic [15:0]      frm_dp      = '0;
    logic [5:0]       frm_flags   = '0;
    logic [CNT_W-1:0] sum_cnt   [SUMMARY_COUNT] = '{default: '0};
    logic [CNT_W-1:0] hist_cnt  [NUM_BUCKETS]   = '{default: '0};
    logic [CNT_W-1:0] proto_cnt [PROTO_SLOTS]   = '{default: '0};

    ipv4_frame_classifier_stats_core #(
        .COUNTER_WIDTH  (CNT_W),
        .MAX_FRAME_BYTES(FRAME_LIMIT),
        .HIST_BUCKETS   (NUM_BUCKETS)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    task automatic clear_frame_state();
        frm_pos   = 0;
        frm_etype = '0;
        frm_vlan  = 1'b0;
        frm_ihl   = 0;
        frm_ttl   = '0;
        frm_proto = '0;
        frm_sp    = '0;
        frm_dp    = '0;
        frm_flags = '0;
    endtask

    task automatic parse_byte(input int p, input logic [7:0] b);
        int ip0;
        int q;
        int r;
        ip0 = frm_vlan ? 18 : 14;
        if (p == 12) frm_etype[15:8] = b;
        if (p == 13) begin
            frm_etype[7:0] = b;
            if (frm_etype == ETH_TYPE_VLAN) frm_vlan = 1'b1;
        end
        if (frm_vlan && p == 16) frm_etype[15:8] = b;
        if (frm_vlan && p == 17) frm_etype[7:0] = b;
        if (p >= ip0) begin
            q = p - ip0;
            if (q == 0) frm_ihl = int'(b[3:0]) * 4;
            if (q == 8) frm_ttl = b;
            if (q == 9) frm_proto = b;
            if (frm_ihl >= 20 && q >= frm_ihl) begin
                r = q - frm_ihl;
                if (r == 0) frm_sp[15:8] = b;
                if (r == 1) frm_sp[7:0] = b;
                if (r == 2) frm_dp[15:8] = b;
                if (r == 3) frm_dp[7:0] = b;
                if (r == 13) frm_flags = b[5:0];
            end
        end
    endtask

    task automatic classify_frame();
        result_t res;
        int      len;
        int      ip0;
        int      l4_bytes;
        int      i;
        bit      tcp_full;
        res        = '0;
        res.kind   = RK_CLASSIFY;
        len        = frm_pos;
        ip0        = frm_vlan ? 18 : 14;
        res.len    = len[LEN_W-1:0];
        res.bucket = BUCKET_NONE;
        for (i = NUM_BUCKETS - 1; i >= 0; i--) begin
            if (len <= (64 << i)) res.bucket = i[BUCKET_W-1:0];
        end
        if (len < 14) begin
            res.status = ST_RUNT;
        end else if ((frm_vlan && len <= 18) || frm_etype != ETH_TYPE_IPV4) begin
            res.status = ST_NOT_IPV4;
        end else if (len - ip0 < 20 || frm_ihl < 20 || frm_ihl > len - ip0) begin
            res.status = ST_BAD_IP_HDR;
        end else begin
            l4_bytes  = len - ip0 - frm_ihl;
            res.ttl   = frm_ttl;
            res.proto = frm_proto;
            tcp_full  = frm_proto == IP_PROTO_TCP && l4_bytes >= 20;
            if (tcp_full || (frm_proto == IP_PROTO_UDP && l4_bytes >= 8)) begin
                res.sp = frm_sp;
                res.dp = frm_dp;
            end
            if (tcp_full) res.flags = frm_flags;
            if (port_filter != 0 && res.sp != port_filter && res.dp != port_filter) begin
                res.status = ST_FILTERED;
            end else begin
                res.status = ST_COUNTED;
                sum_cnt[SUM_PACKETS] += 1;
                sum_cnt[SUM_BYTES]   += len;
                sum_cnt[SUM_IP]      += 1;
                case (frm_proto)
                    IP_PROTO_TCP:  sum_cnt[SUM_TCP]   += 1;
                    IP_PROTO_UDP:  sum_cnt[SUM_UDP]   += 1;
                    IP_PROTO_ICMP: sum_cnt[SUM_ICMP]  += 1;
                    default:       sum_cnt[SUM_OTHER] += 1;
                endcase
                proto_cnt[frm_proto] += 1;
                if (res.bucket != BUCKET_NONE) hist_cnt[res.bucket] += 1;
            end
        end
        expected_results.push_back(res);
    endtask

    task automatic predict_request(input request_t r);
        result_t res;
        int      sel;
        if (r.op == OP_COUNTER_READ) begin
            res      = '0;
            res.kind = RK_COUNTER;
            sel      = r.sel;
            if (sel < SUMMARY_COUNT)
                res.value = sum_cnt[sel];
            else if (sel < PROTO_SEL_BASE)
                res.value = hist_cnt[sel - SUMMARY_COUNT];
            else if (sel < PROTO_SEL_BASE + PROTO_SLOTS)
                res.value = proto_cnt[sel - PROTO_SEL_BASE];
            expected_results.push_back(res);
        end else begin
            if (frm_pos < FRAME_LIMIT) begin
                parse_byte(frm_pos, r.data);
                frm_pos++;
            end
            if (r.last) begin
                classify_frame();
                clear_frame_state();
            end
        end
    endtask

    // ---------------------------------------------------------------- driver and monitor

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_request(in_flight);
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_flight = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'd0, in_flight.sel, in_flight.data};
                    s_tlast  <= in_flight.last;
                    s_tuser  <= in_flight.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    task automatic check_result();
        result_t want;
        if (expected_results.size() == 0) begin
            $error("result with nothing expected: kind %0d data %h", m_tuser, m_tdata);
            error_count++;
        end else begin
            want = expected_results.pop_front();
            check_field("result_kind",   want.kind,   m_tuser[0]);
            check_field("frame_status",  want.status, m_tdata[2:0]);
            check_field("ip_protocol",   want.proto,  m_tdata[10:3]);
            check_field("source_port",   want.sp,     m_tdata[26:11]);
            check_field("dest_port",     want.dp,     m_tdata[42:27]);
            check_field("time_to_live",  want.ttl,    m_tdata[50:43]);
            check_field("tcp_flag_bits", want.flags,  m_tdata[56:51]);
            check_field("frame_length",  want.len,    m_tdata[73:57]);
            check_field("size_bucket",   want.bucket, m_tdata[77:74]);
            check_field("counter_value", want.value,  m_tdata[125:78]);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_result();
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("** ipv4_frame_classifier_stats_core: FAILED **");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic push_byte(input logic [7:0] b, input logic last);
        request_t r;
        r.op   = OP_FRAME_BYTE;
        r.data = b;
        r.last = last;
        r.sel  = 9'($urandom_range(SEL_MAX));
        pending_requests.push_back(r);
        queued_items++;
    endtask

    task automatic push_read(input int sel);
        request_t r;
        r.op   = OP_COUNTER_READ;
        r.data = 8'($urandom_range(255));
        r.last = 1'($urandom_range(1));
        r.sel  = sel[8:0];
        pending_requests.push_back(r);
        queued_items++;
    endtask

    function automatic int random_sel();
        if ($urandom_range(99) < 90) return $urandom_range(PROTO_SEL_BASE + PROTO_SLOTS - 1);
        return $urandom_range(SEL_MAX);
    endfunction

    function automatic logic [15:0] pick_port();
        case ($urandom_range(4))
            0, 1:    return (port_filter != 0) ? port_filter : 16'($urandom_range(65535));
            2:       return 16'($urandom_range(65535));
            3:       return 16'hFFFF;
            default: return 16'h0000;
        endcase
    endfunction

    // Builds a frame of len bytes with the given headers; bytes not placed by a header
    // are random, and counter reads may be slipped in between the bytes.
    task automatic send_frame(input bit has_vlan, input logic [15:0] etype,
                              input logic [7:0] ver_ihl, input logic [7:0] ttl,
                              input logic [7:0] proto, input logic [15:0] sp,
                              input logic [15:0] dp, input logic [7:0] flag_byte,
                              input int len, input bit mid_reads);
        logic [7:0] hdr [128];
        int         ip0;
        int         l4;
        int         k;
        for (k = 0; k < 128; k++) hdr[k] = 8'($urandom_range(255));
        ip0 = has_vlan ? 18 : 14;
        hdr[12] = has_vlan ? ETH_TYPE_VLAN[15:8] : etype[15:8];
        hdr[13] = has_vlan ? ETH_TYPE_VLAN[7:0] : etype[7:0];
        if (has_vlan) begin
            hdr[16] = etype[15:8];
            hdr[17] = etype[7:0];
        end
        hdr[ip0]     = ver_ihl;
        hdr[ip0 + 8] = ttl;
        hdr[ip0 + 9] = proto;
        l4 = ip0 + int'(ver_ihl[3:0]) * 4;
        if (ver_ihl[3:0] >= 5) begin
            hdr[l4]      = sp[15:8];
            hdr[l4 + 1]  = sp[7:0];
            hdr[l4 + 2]  = dp[15:8];
            hdr[l4 + 3]  = dp[7:0];
            hdr[l4 + 13] = flag_byte;
        end
        for (k = 0; k < len; k++) begin
            if (mid_reads && k > 0 && $urandom_range(99) < 3) push_read(random_sel());
            push_byte((k < 128) ? hdr[k] : 8'($urandom_range(255)), k == len - 1);
        end
        queued_frames++;
    endtask

    // Mostly well-formed frames with random content, plus runts, truncations and odd types.
    task automatic random_frame();
        bit          v;
        logic [15:0] et;
        logic [7:0]  vi;
        logic [7:0]  pr;
        int          pick;
        int          ip0;
        int          l4;
        int          full;
        int          len;
        v    = $urandom_range(99) < 25;
        pick = $urandom_range(99);
        et   = (pick < 88) ? ETH_TYPE_IPV4 : (pick < 94) ? 16'h86DD : 16'($urandom_range(65535));
        pick = $urandom_range(99);
        vi   = (pick < 75) ? 8'h45 :
               (pick < 90) ? {4'h4, 4'($urandom_range(15, 6))} : 8'($urandom_range(255));
        pick = $urandom_range(99);
        pr   = (pick < 40) ? IP_PROTO_TCP : (pick < 70) ? IP_PROTO_UDP :
               (pick < 80) ? IP_PROTO_ICMP : 8'($urandom_range(255));
        ip0  = v ? 18 : 14;
        l4   = ip0 + ((vi[3:0] >= 5) ? int'(vi[3:0]) * 4 : 20);
        full = l4 + ((pr == IP_PROTO_TCP) ? 20 : 8);
        case ($urandom_range(9))
            0:       len = $urandom_range(20, 1);
            1:       len = $urandom_range(l4 + 2, ip0);
            2, 3:    len = $urandom_range(full + 1, l4);
            default: len = full + $urandom_range(24);
        endcase
        send_frame(v, et, vi, 8'($urandom_range(255)), pr, pick_port(), pick_port(),
                   8'($urandom_range(255)), len, 1'b1);
    endtask

    task automatic wait_idle(input int extra);
        while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_port_filter(input logic [15:0] value);
        wait_idle(SETTLE_CYCLES);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        port_filter = value;
    endtask

    task automatic run_segment(input logic [15:0] filter, input int send_pct, input int recv_pct,
                               input bit pause_midway);
        int  first_item;
        int  first_frame;
        bit  paused;
        write_port_filter(filter);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        first_item    = queued_items;
        first_frame   = queued_frames;
        paused        = 1'b0;
        while (queued_items - first_item < SEG_REQUESTS ||
               queued_frames - first_frame < SEG_FRAMES) begin
            // The sender holds off once until every pending request has its result.
            if (pause_midway && !paused && queued_items - first_item >= SEG_REQUESTS / 2) begin
                paused = 1'b1;
                wait_idle(0);
            end
            if ($urandom_range(99) < 12) push_read(random_sel());
            else random_frame();
        end
    endtask

    initial begin
        int i;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        write_port_filter(16'h0000);

        push_read(SUM_PACKETS);
        send_frame(0, ETH_TYPE_IPV4, 8'h45, 8'h40, IP_PROTO_TCP, 16'h1234, 16'h0050, 8'h12, 1, 0);
        send_frame(0, ETH_TYPE_IPV4, 8'h45, 8'h40, IP_PROTO_TCP, 16'h1234, 16'h0050, 8'h12, 13, 0);
        send_frame(0, ETH_TYPE_IPV4, 8'h45, 8'h40, IP_PROTO_TCP, 16'h1234, 16'h0050, 8'h12, 14, 0);
        send_frame(0, ETH_TYPE_IPV4, 8'h45, 8'hFF, IP_PROTO_TCP, 16'hFFFF, 16'h0000, 8'hFF, 54, 0);
        send_frame(0, ETH_TYPE_IPV4, 8'h45, 8'h00, IP_PROTO_UDP, 16'h0035, 16'hC001, 8'h00, 42, 0);
        send_frame(0, ETH_TYPE_IPV4, 8'h45, 8'h80, IP_PROTO_TCP, 16'hABCD, 16'h1F90, 8'h02, 53, 0);
        send_frame(0, ETH_TYPE_IPV4, 8'h45, 8'h01, IP_PROTO_UDP, 16'h0044, 16'h0043, 8'h00, 41, 0);
        send_frame(1, ETH_TYPE_IPV4, 8'h45, 8'h40, IP_PROTO_TCP, 16'h0016, 16'h8000, 8'h10, 18, 0);
        send_frame(1, ETH_TYPE_IPV4, 8'h45, 8'h3C, IP_PROTO_TCP, 16'h0016, 16'h8000, 8'h18, 58, 0);
        send_frame(0, 16'h86DD, 8'h45, 8'h40, IP_PROTO_TCP, 16'h0016, 16'h8000, 8'h10, 60, 0);
        send_frame(0, ETH_TYPE_IPV4, 8'h44, 8'h40, IP_PROTO_UDP, 16'h0001, 16'h0002, 8'h00, 60, 0);
        send_frame(0, ETH_TYPE_IPV4, 8'h4F, 8'h40, IP_PROTO_UDP, 16'h0001, 16'h0002, 8'h00, 73, 0);
        send_frame(0, ETH_TYPE_IPV4, 8'h6F, 8'h22, IP_PROTO_TCP, 16'h0101, 16'h0202, 8'hC1, 94, 0);
        send_frame(0, ETH_TYPE_IPV4, 8'h45, 8'h40, IP_PROTO_ICMP, 16'h0800, 16'h0000, 8'h00, 64, 0);
        send_frame(0, ETH_TYPE_IPV4, 8'h45, 8'h40, 8'hFF, 16'h5555, 16'hAAAA, 8'h00, 65, 0);
        push_read(SUM_BYTES);
        push_read(SUMMARY_COUNT);
        push_read(PROTO_SEL_BASE + IP_PROTO_TCP);
        push_read(PROTO_SEL_BASE + PROTO_SLOTS - 1);
        push_read(PROTO_SEL_BASE + PROTO_SLOTS);
        push_read(SEL_MAX);

        run_segment(16'h0000, 27, 69, 0);
        run_segment(16'd443, 27, 69, 1);
        run_segment(16'hFFFF, 69, 27, 0);
        run_segment(16'($urandom_range(65534, 1)), 69, 27, 1);
        run_segment(16'h0000, 0, 0, 0);

        // Final sweep of the summary and histogram counters and the UDP, ICMP and 255 protocol counters.
        for (i = 0; i < PROTO_SEL_BASE; i++) push_read(i);
        push_read(PROTO_SEL_BASE + IP_PROTO_UDP);
        push_read(PROTO_SEL_BASE + IP_PROTO_ICMP);
        push_read(PROTO_SEL_BASE + 8'hFF);

        wait_idle(END_CYCLES);
        if (error_count == 0) begin
            $display("** ipv4_frame_classifier_stats_core: PASSED **");
        end else begin
            $display("** ipv4_frame_classifier_stats_core: FAILED **");
        end
        $finish;
    end

endmodule
